// File: rtl/core/round_robin_packet_scheduler_core_assert.svh
// assertion macros shared by the scheduler rtl
// each macro expects clk and rst_n in the scope where it is used
`ifndef ROUND_ROBIN_PACKET_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_PACKET_SCHEDULER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RRPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RRPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rrps_pkg.sv
// shared types and codes of the round-robin packet scheduler
// no dependencies
package rrps_pkg;

    localparam int TIME_W     = 48;
    localparam int TAG_W      = 32;
    localparam int LEN_W      = 16;
    localparam int RATE_W     = 32;
    localparam int QSEL_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int MAX_QUEUES = 4;

    // 1.0 in q16.16
    localparam logic [RATE_W-1:0] RATE_RESET = 32'h0001_0000;

    localparam logic KIND_ENQUEUE  = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  length;
    } slot_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic              any;
        logic [QSEL_W-1:0] queue;
    } pick_t;

endpackage

// File: rtl/core/rrps_queue.sv
// one packet fifo with its head held in a register, refilled from the memory
// depends on rrps_pkg and the assertion macro header
`include "round_robin_packet_scheduler_core_assert.svh"

module rrps_queue
    import rrps_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_ctrl_t ctrl,
    input  slot_t       push_data,
    output queue_stat_t stat,
    output slot_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    slot_t            mem [DEPTH];
    slot_t            head_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // read at the next head address so the head register is current after every edge;
    // a push into an empty queue lands straight in the head register
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (ctrl.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_data;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head          = head_reg;
    assign stat.nonempty = (count_reg != '0);
    assign stat.full     = (count_reg == CNT_FULL);

    `RRPS_ASSERT_SAME(a_no_push_when_full, ctrl.push, count_reg != CNT_FULL, "push into full queue")
    `RRPS_ASSERT_SAME(a_no_pop_when_empty, ctrl.pop, count_reg != '0, "pop from empty queue")
    `RRPS_ASSERT_NEXT(a_push_fills, ctrl.push, stat.nonempty, "queue empty after push")

endmodule

// File: rtl/core/rrps_select.sv
// queue picker: first overdue head in round-robin order, else earliest head
// depends on rrps_pkg
module rrps_select
    import rrps_pkg::*;
#(
    parameter int QUEUE_COUNT = 4
)
(
    input  logic [QSEL_W-1:0] last_served,
    input  queue_stat_t       stat         [MAX_QUEUES],
    input  logic [TIME_W-1:0] arrival      [MAX_QUEUES],
    input  logic [TIME_W-1:0] current_time,
    output pick_t             pick
);

    logic [QSEL_W-1:0] ord_q [MAX_QUEUES];
    logic              ord_v [MAX_QUEUES];
    logic [TIME_W-1:0] ord_a [MAX_QUEUES];
    logic              win   [MAX_QUEUES];
    logic              found;
    logic [QSEL_W-1:0] pick_first;
    logic [QSEL_W-1:0] pick_min;
    logic              any_queued;

    // queues laid out in scan order, starting after the last served one
    always_comb
    begin
        logic [QSEL_W:0] slot;
        for (int k = 0; k < MAX_QUEUES; k++)
        begin
            slot = {1'b0, last_served} + (QSEL_W+1)'(k + 1);
            if (slot >= (QSEL_W+1)'(QUEUE_COUNT))
            begin
                slot = slot - (QSEL_W+1)'(QUEUE_COUNT);
            end
            ord_q[k] = slot[QSEL_W-1:0];
            ord_v[k] = (k < QUEUE_COUNT) && stat[slot[QSEL_W-1:0]].nonempty;
            ord_a[k] = arrival[slot[QSEL_W-1:0]];
        end
    end

    // first head that arrived strictly before now
    always_comb
    begin
        found      = 1'b0;
        pick_first = '0;
        for (int k = 0; k < MAX_QUEUES; k++)
        begin
            if (!found && ord_v[k] && (ord_a[k] < current_time))
            begin
                found      = 1'b1;
                pick_first = ord_q[k];
            end
        end
    end

    // earliest head, ties to the one met first in scan order
    always_comb
    begin
        for (int k = 0; k < MAX_QUEUES; k++)
        begin
            win[k] = ord_v[k];
            for (int j = 0; j < MAX_QUEUES; j++)
            begin
                if ((j != k) && ord_v[j])
                begin
                    if (j < k)
                    begin
                        if (!(ord_a[k] < ord_a[j]))
                        begin
                            win[k] = 1'b0;
                        end
                    end
                    else if (!(ord_a[k] <= ord_a[j]))
                    begin
                        win[k] = 1'b0;
                    end
                end
            end
        end
        pick_min   = '0;
        any_queued = 1'b0;
        for (int k = 0; k < MAX_QUEUES; k++)
        begin
            if (win[k])
            begin
                pick_min = ord_q[k];
            end
            any_queued = any_queued | ord_v[k];
        end
    end

    always_comb
    begin
        pick.any   = any_queued;
        pick.queue = found ? pick_first : pick_min;
    end

endmodule

// File: rtl/core/round_robin_packet_scheduler_core.sv
// round-robin packet scheduler core, top level; uses rrps_pkg, rrps_queue, rrps_select and
// the assertion macro header. each accepted item gives exactly one result item; it passes
// through the input register and then the result register, from which it shows on the
// outputs. a new item is taken every cycle while the result side keeps up. an enqueue item
// stores a packet in its queue or reports a drop when the queue is full or the queue number
// is out of range. a dispatch item picks the first queue, after the last served one, whose
// head arrived before the current time, else the queue with the earliest head; the packet
// departs at max(now, arrival) + length * time_per_length_unit, saturating at the top of
// the 48-bit q32.16 range, and that time becomes the new current time. with nothing queued
// a dispatch reports idle. the one item per cycle figure is set by each queue keeping its
// head packet in a register that the queue memory refills at the next head address on every
// edge. the user is to write the rate register only while the block holds no work; the
// block itself does not enforce this; there is no clearing pass
module round_robin_packet_scheduler_core
    import rrps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int QUEUE_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,

    // rate register
    input  logic                cfg_write_enable,
    input  logic [RATE_W-1:0]   cfg_write_data,

    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [QSEL_W-1:0]   queue_select,
    input  logic [TIME_W-1:0]   arrival_time,
    input  logic [TAG_W-1:0]    packet_tag,
    input  logic [LEN_W-1:0]    packet_length,

    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TIME_W-1:0]   departure_time,
    output logic [TAG_W-1:0]    served_tag,
    output logic [QSEL_W-1:0]   served_queue
);

`include "round_robin_packet_scheduler_core_assert.svh"

    // rate register, q16.16
    logic [RATE_W-1:0]   tpu_reg;

    // input register
    logic                in_valid_reg;
    logic                kind_reg;
    logic [QSEL_W-1:0]   queue_select_reg;
    logic [TIME_W-1:0]   arrival_time_reg;
    logic [TAG_W-1:0]    packet_tag_reg;
    logic [LEN_W-1:0]    packet_length_reg;

    // scheduler state
    logic [TIME_W-1:0]   current_time_reg;
    logic [TIME_W-1:0]   current_time_next;
    logic [QSEL_W-1:0]   last_served_reg;
    logic [QSEL_W-1:0]   last_served_next;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TIME_W-1:0]   departure_reg;
    logic [TIME_W-1:0]   departure_next;
    logic [TAG_W-1:0]    served_tag_reg;
    logic [TAG_W-1:0]    served_tag_next;
    logic [QSEL_W-1:0]   served_queue_reg;
    logic [QSEL_W-1:0]   served_queue_next;

    // queue side
    slot_t               push_slot;
    slot_t               head         [MAX_QUEUES];
    queue_stat_t         stat         [MAX_QUEUES];
    queue_ctrl_t         ctrl         [MAX_QUEUES];
    logic [TIME_W-1:0]   head_arrival [MAX_QUEUES];
    logic [TIME_W-1:0]   dep_q        [MAX_QUEUES];
    pick_t               pick;

    logic                advance;
    logic                is_dispatch;
    logic                enq_ok;
    logic                serve;

    // item in the input register moves on when the result register is free or drains
    assign advance     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = in_valid_reg && !advance;
    assign is_dispatch = (kind_reg == KIND_DISPATCH);
    assign enq_ok      = !is_dispatch
                         && ({1'b0, queue_select_reg} < (QSEL_W+1)'(QUEUE_COUNT))
                         && !stat[queue_select_reg].full;
    assign serve       = advance && is_dispatch && pick.any;

    assign push_slot.arrival = arrival_time_reg;
    assign push_slot.tag     = packet_tag_reg;
    assign push_slot.length  = packet_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= RATE_RESET;
        end
        else if (cfg_write_enable)
        begin
            tpu_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg          <= kind;
            queue_select_reg  <= queue_select;
            arrival_time_reg  <= arrival_time;
            packet_tag_reg    <= packet_tag;
            packet_length_reg <= packet_length;
        end
    end

    // per queue: fifo, push/pop strobes and the departure time its head would get
    for (genvar g = 0; g < MAX_QUEUES; g++)
    begin : g_queue
        if (g < QUEUE_COUNT)
        begin : g_live
            logic [TIME_W-1:0] start;
            logic [TIME_W-1:0] service;
            logic [TIME_W:0]   finish;

            assign ctrl[g].push = advance && enq_ok && (queue_select_reg == QSEL_W'(g));
            assign ctrl[g].pop  = serve && (pick.queue == QSEL_W'(g));

            rrps_queue #(
                .DEPTH (QUEUE_DEPTH)
            ) u_queue (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl[g]),
                .push_data (push_slot),
                .stat      (stat[g]),
                .head      (head[g])
            );

            // length * rate is exact in 48 bits
            assign start   = (head[g].arrival > current_time_reg) ? head[g].arrival
                                                                   : current_time_reg;
            assign service = head[g].length * tpu_reg;
            assign finish  = {1'b0, start} + {1'b0, service};
            assign dep_q[g] = finish[TIME_W] ? '1 : finish[TIME_W-1:0];
        end
        else
        begin : g_absent
            // missing queue: never holds a packet, always refuses
            assign ctrl[g]          = '0;
            assign stat[g].nonempty = 1'b0;
            assign stat[g].full     = 1'b1;
            assign head[g]          = '0;
            assign dep_q[g]         = '0;
        end

        assign head_arrival[g] = head[g].arrival;
    end

    rrps_select #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_select (
        .last_served  (last_served_reg),
        .stat         (stat),
        .arrival      (head_arrival),
        .current_time (current_time_reg),
        .pick         (pick)
    );

    always_comb
    begin
        status_next       = STATUS_ACCEPTED;
        departure_next    = '0;
        served_tag_next   = '0;
        served_queue_next = '0;
        current_time_next = current_time_reg;
        last_served_next  = last_served_reg;
        if (!is_dispatch)
        begin
            status_next = enq_ok ? STATUS_ACCEPTED : STATUS_DROPPED;
        end
        else if (!pick.any)
        begin
            status_next = STATUS_IDLE;
        end
        else
        begin
            status_next       = STATUS_SERVED;
            departure_next    = dep_q[pick.queue];
            served_tag_next   = head[pick.queue].tag;
            served_queue_next = pick.queue;
            current_time_next = dep_q[pick.queue];
            last_served_next  = pick.queue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_time_reg <= '0;
            last_served_reg  <= QSEL_W'(QUEUE_COUNT - 1);
        end
        else if (serve)
        begin
            current_time_reg <= current_time_next;
            last_served_reg  <= last_served_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg       <= status_next;
            departure_reg    <= departure_next;
            served_tag_reg   <= served_tag_next;
            served_queue_reg <= served_queue_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign departure_time = departure_reg;
    assign served_tag     = served_tag_reg;
    assign served_queue   = served_queue_reg;

    // served packet never departs before the time it was scheduled at
    `RRPS_ASSERT_NEXT(a_time_forward, serve, current_time_reg >= $past(current_time_reg), "time went back")
    // the new current time is the reported departure
    `RRPS_ASSERT_NEXT(a_time_is_dep, serve, current_time_reg == departure_reg, "time not departure")
    // the picker only ever chooses a queue that holds a packet
    `RRPS_ASSERT_SAME(a_pick_nonempty, serve, stat[pick.queue].nonempty, "served queue is empty")
    // round-robin position only moves on a served dispatch
    `RRPS_ASSERT_NEXT(a_last_holds, !serve, $stable(last_served_reg), "last served moved")

endmodule

// File: dv/tb_round_robin_packet_scheduler_core.sv
`timescale 1ns / 100ps
// self-checking testbench for round_robin_packet_scheduler_core
// depends on rrps_pkg and the scheduler rtl; holds its own scheduling predictor and scoreboard

module tb_round_robin_packet_scheduler_core;
    import rrps_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_COUNT = 4;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one result item as the block reports it
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   departure;
        logic [TAG_W-1:0]    tag;
        logic [QSEL_W-1:0]   src_queue;
    } sched_result_t;

    // traffic mix of the random part
    typedef enum {FILL, DRAIN, MIXED} traffic_mode_t;

    // scoreboard: keeps a shadow of the four packet queues, the scheduler clock and the
    // rate, works out each expected result when an item is accepted, and checks results
    // against them in order
    class sched_scoreboard;
        logic [TIME_W-1:0] arrival_of [QUEUE_COUNT][QUEUE_DEPTH];
        logic [TAG_W-1:0]  tag_of     [QUEUE_COUNT][QUEUE_DEPTH];
        logic [LEN_W-1:0]  length_of  [QUEUE_COUNT][QUEUE_DEPTH];
        int                head       [QUEUE_COUNT];
        int                fill       [QUEUE_COUNT];
        logic [TIME_W-1:0] now         = '0;
        int                last_served = QUEUE_COUNT - 1;
        logic [RATE_W-1:0] rate        = RATE_RESET;
        sched_result_t     awaited [$];
        int                errors      = 0;

        function sched_result_t schedule_item(logic kd, logic [QSEL_W-1:0] qsel,
                                              logic [TIME_W-1:0] arr, logic [TAG_W-1:0] tg,
                                              logic [LEN_W-1:0] len);
            sched_result_t           res;
            int                      pick;
            int                      q;
            int                      slot;
            bit                      found;
            logic [TIME_W-1:0]       best;
            logic [TIME_W-1:0]       begins_at;
            logic [TIME_W+RATE_W:0]  done_at;
            res = '{STATUS_ACCEPTED, '0, '0, '0};
            if (kd == KIND_ENQUEUE)
            begin
                if (qsel >= QUEUE_COUNT || fill[qsel] >= QUEUE_DEPTH)
                begin
                    res.status = STATUS_DROPPED;
                end
                else
                begin
                    slot = (head[qsel] + fill[qsel]) % QUEUE_DEPTH;
                    arrival_of[qsel][slot] = arr;
                    tag_of[qsel][slot]     = tg;
                    length_of[qsel][slot]  = len;
                    fill[qsel]++;
                end
                return res;
            end
            found = 0;
            pick  = 0;
            best  = '0;
            // first queue after the last served one whose head is already late
            for (int step = 1; step <= QUEUE_COUNT && !found; step++)
            begin
                q = (last_served + step) % QUEUE_COUNT;
                if (fill[q] != 0 && arrival_of[q][head[q]] < now)
                begin
                    pick  = q;
                    found = 1;
                end
            end
            // else earliest head, first in scan order wins a tie
            if (!found)
            begin
                for (int step = 1; step <= QUEUE_COUNT; step++)
                begin
                    q = (last_served + step) % QUEUE_COUNT;
                    if (fill[q] != 0 && (!found || arrival_of[q][head[q]] < best))
                    begin
                        best  = arrival_of[q][head[q]];
                        pick  = q;
                        found = 1;
                    end
                end
            end
            if (!found)
            begin
                res.status = STATUS_IDLE;
                return res;
            end
            slot      = head[pick];
            begins_at = arrival_of[pick][slot] > now ? arrival_of[pick][slot] : now;
            done_at   = begins_at + length_of[pick][slot] * rate;
            res.status    = STATUS_SERVED;
            res.departure = done_at > TIME_MAX ? TIME_MAX : done_at[TIME_W-1:0];
            res.tag       = tag_of[pick][slot];
            res.src_queue = QSEL_W'(pick);
            now         = res.departure;
            head[pick]  = (head[pick] + 1) % QUEUE_DEPTH;
            fill[pick]--;
            last_served = pick;
            return res;
        endfunction

        function void note_item(logic kd, logic [QSEL_W-1:0] qsel, logic [TIME_W-1:0] arr,
                                logic [TAG_W-1:0] tg, logic [LEN_W-1:0] len);
            awaited.insert(awaited.size(), schedule_item(kd, qsel, arr, tg, len));
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual status %0d",
                         $time, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.departure !== want.departure)
            begin
                errors++;
                $display("%0t: departure_time expected %h actual %h",
                         $time, want.departure, got.departure);
            end
            if (got.tag !== want.tag)
            begin
                errors++;
                $display("%0t: served_tag expected %h actual %h", $time, want.tag, got.tag);
            end
            if (got.src_queue !== want.src_queue)
            begin
                errors++;
                $display("%0t: served_queue expected %0d actual %0d",
                         $time, want.src_queue, got.src_queue);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_enable;
    logic [RATE_W-1:0]   cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [QSEL_W-1:0]   queue_select;
    logic [TIME_W-1:0]   arrival_time;
    logic [TAG_W-1:0]    packet_tag;
    logic [LEN_W-1:0]    packet_length;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   departure_time;
    logic [TAG_W-1:0]    served_tag;
    logic [QSEL_W-1:0]   served_queue;

    sched_scoreboard sb;
    // random gaps on both sides while set
    bit              idling = 0;

    always #1 clk = ~clk;

    round_robin_packet_scheduler_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .queue_select     (queue_select),
        .arrival_time     (arrival_time),
        .packet_tag       (packet_tag),
        .packet_length    (packet_length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .departure_time   (departure_time),
        .served_tag       (served_tag),
        .served_queue     (served_queue)
    );

    // present one item, hold it through any stall, and log it with the predictor on the
    // edge that takes it; the valid stays high into the next item unless a gap is drawn
    task automatic send_item(input logic kd, input logic [QSEL_W-1:0] qsel,
                             input logic [TIME_W-1:0] arr, input logic [TAG_W-1:0] tg,
                             input logic [LEN_W-1:0] len);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        kind          <= kd;
        queue_select  <= qsel;
        arrival_time  <= arr;
        packet_tag    <= tg;
        packet_length <= len;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(kd, qsel, arr, tg, len);
    endtask

    // rate changes only with the block drained; every item gives a result, so once the
    // scoreboard is empty the short pause just covers the two-stage pipeline
    task automatic set_rate(input logic [RATE_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        sb.rate = value;
    endtask

    // arrivals mostly sit just before or just after the scheduler clock so that both the
    // late-head scan and the earliest-head fallback get exercised; repeats give ties;
    // wide mode adds full-range times, which push the clock into saturation
    function automatic logic [TIME_W-1:0] pick_arrival(bit wide, logic [TIME_W-1:0] prev);
        logic [TIME_W-1:0] now_t;
        logic [TIME_W-1:0] offset;
        logic [63:0]       full;
        now_t  = sb.now;
        offset = $urandom_range(1, 1 << 20);
        full   = {$urandom, $urandom};
        if (wide && $urandom_range(0, 1) == 1)
            return full[TIME_W-1:0];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return now_t > offset ? now_t - offset : '0;
            4, 5, 6:    return (TIME_MAX - now_t > offset) ? now_t + offset : TIME_MAX;
            7:          return now_t;
            8:          return prev;
            default:    return offset;
        endcase
    endfunction

    // short packets mostly; long ones stay rare outside wide mode so the clock does not
    // saturate before the last phases
    function automatic logic [LEN_W-1:0] pick_length(bit wide);
        case ($urandom_range(0, 19))
            0:       return '1;
            1:       return '0;
            2:       return LEN_W'($urandom);
            3:       return wide ? LEN_W'($urandom) : LEN_W'($urandom_range(1, 15));
            default: return LEN_W'($urandom_range(1, 15));
        endcase
    endfunction

    // one phase: program the rate, then a random stream that wanders between filling
    // (to reach full queues and drops), draining (to reach idle) and an even mix
    task automatic run_phase(input logic [RATE_W-1:0] rate_value, input int count,
                             input bit wide);
        traffic_mode_t     mode;
        int                enq_pct;
        logic [QSEL_W-1:0] hot;
        logic [QSEL_W-1:0] qsel;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] last_arr;
        logic              kd;
        set_rate(rate_value);
        mode     = MIXED;
        hot      = QSEL_W'($urandom);
        last_arr = sb.now;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                mode = traffic_mode_t'($urandom_range(0, 2));
                hot  = QSEL_W'($urandom);
            end
            enq_pct = (mode == FILL) ? 85 : (mode == DRAIN) ? 15 : 50;
            kd      = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQUEUE : KIND_DISPATCH;
            qsel    = $urandom_range(0, 1) ? hot : QSEL_W'($urandom);
            arr     = pick_arrival(wide, last_arr);
            send_item(kd, qsel, arr, $urandom, pick_length(wide));
            if (kd == KIND_ENQUEUE)
                last_arr = arr;
        end
    endtask

    // result side: take every result on the edge where it is handed over
    always @(posedge clk)
    begin : result_monitor
        sched_result_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status, departure_time, served_tag, served_queue};
            sb.check_result(got);
        end
    end

    // receiver back-pressure in random bursts, none once idling is switched off
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idling && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        sb = new;
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_write_data   <= '0;
        in_valid         <= 1'b0;
        kind             <= KIND_ENQUEUE;
        queue_select     <= '0;
        arrival_time     <= '0;
        packet_tag       <= '0;
        packet_length    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dispatch with nothing queued, ignored fields at their extremes
        send_item(KIND_DISPATCH, 2'd3, TIME_MAX, '1, '1);
        // two heads at time zero, zero and full length: tie goes to queue 0 first
        send_item(KIND_ENQUEUE, 2'd0, '0, '0, '0);
        send_item(KIND_ENQUEUE, 2'd1, '0, '1, '1);
        send_item(KIND_DISPATCH, '0, '0, '0, '0);
        send_item(KIND_DISPATCH, '0, '0, '0, '0);
        // fill queue 2 past its depth; the last one is dropped
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_item(KIND_ENQUEUE, 2'd2, TIME_W'(i) << 16, TAG_W'(i), LEN_W'(1));
        // late head in queue 2 wins, then the scan wraps to queue 3 ahead of queue 2
        send_item(KIND_DISPATCH, '0, '0, '0, '0);
        send_item(KIND_ENQUEUE, 2'd3, TIME_W'(1), 32'h5A5A_A5A5, LEN_W'(3));
        send_item(KIND_DISPATCH, '0, '0, '0, '0);

        // random phases over a range of rates, clock kept well below saturation
        idling = 1;
        run_phase(RATE_RESET, 210, 0);
        run_phase('0, 210, 0);
        run_phase(32'd1, 210, 0);
        run_phase(RATE_W'($urandom_range(0, 1 << 18)), 210, 0);
        run_phase(32'h0004_0000, 210, 0);
        run_phase(32'h0001_8000, 210, 0);
        // full-range times and rates, ending in saturation with no gaps or stalls
        run_phase(RATE_W'($urandom), 120, 1);
        idling = 0;
        run_phase('1, 80, 1);

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rrps_pkg.sv
rtl/core/rrps_queue.sv
rtl/core/rrps_select.sv
rtl/core/round_robin_packet_scheduler_core.sv
dv/tb_round_robin_packet_scheduler_core.sv
